[rtl/assert_macros.svh]
// Assertion macros shared by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define FWR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fwr check failed");
`define FWR_ASSERT_ANY(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("fwr check failed");
`else
`define FWR_ASSERT(lbl, prop)
`define FWR_ASSERT_ANY(lbl, prop)
`endif

`endif

[rtl/fwr_pkg.sv]
package fwr_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_QUERY  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] tag;
    logic [30:0] amount;
    logic [30:0] price;
  } rec_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic        en;
    logic        append;
    logic        remove;
    logic [63:0] key;
    rec_t        rec;
  } cmd_t;

endpackage

[rtl/fwr_cmd_if.sv]
interface fwr_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] item_key;
  logic [63:0] item_tag;
  logic [30:0] item_amount;
  logic [30:0] item_price;

  modport source (
    output valid, func, item_key, item_tag, item_amount, item_price,
    input  ready
  );
  modport sink (
    input  valid, func, item_key, item_tag, item_amount, item_price,
    output ready
  );
endinterface

[rtl/fwr_res_if.sv]
interface fwr_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        head_valid;
  logic [63:0] head_key;
  logic [63:0] head_tag;
  logic [30:0] head_amount;
  logic [30:0] head_price;
  logic [4:0]  entry_count;

  modport source (
    output valid, status, head_valid, head_key, head_tag, head_amount,
           head_price, entry_count,
    input  ready
  );
  modport sink (
    input  valid, status, head_valid, head_key, head_tag, head_amount,
           head_price, entry_count,
    output ready
  );
endinterface

[rtl/fifo_with_remove_by_key_core.sv]
// Channel  Dir  Modport  Transaction
// cmd_i    in   sink     func, item_key, item_tag, item_amount, item_price
// res_o    out  source   status, head record with head_valid, entry_count
//
// One command per cycle; its result is registered and appears in the cycle after acceptance.
// The rate is set by the cell chain: every cell compares its key and shifts
// in the same cycle, with the first-match flag rippling along the row.
// A stalled result holds the output register; cmd_i.ready drops only then.
// Reset empties the queue at once; stored records need no clearing.
`include "assert_macros.svh"

module fifo_with_remove_by_key_core (
  input  logic clk_i,
  input  logic rst_ni,
  fwr_cmd_if.sink   cmd_i,
  fwr_res_if.source res_o
);

  localparam int unsigned Depth = fwr_pkg::Depth;
  localparam int unsigned CntW  = fwr_pkg::CntW;

  fwr_pkg::cmd_t        cmd;
  logic [Depth-1:0]     valid_vec;
  logic [Depth-1:0]     valid_d_vec;
  fwr_pkg::rec_t        rec_vec   [Depth];
  fwr_pkg::rec_t        rec_d_vec [Depth];
  logic [Depth:0]       gap_w;
  logic                 accept;
  logic [CntW-1:0]      count_q, count_d;
  fwr_pkg::status_e     status;
  logic [CntW+4:0]      cnt_ext;

  logic                 res_valid_q;
  fwr_pkg::status_e     res_status_q;
  logic                 res_head_valid_q;
  fwr_pkg::rec_t        res_head_q;
  logic [4:0]           res_count_q;

  assign cmd_i.ready = !res_valid_q || res_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;

  always_comb begin
    cmd.en         = accept;
    cmd.append     = 1'b0;
    cmd.remove     = 1'b0;
    cmd.key        = cmd_i.item_key;
    cmd.rec.key    = cmd_i.item_key;
    cmd.rec.tag    = cmd_i.item_tag;
    cmd.rec.amount = cmd_i.item_amount;
    cmd.rec.price  = cmd_i.item_price;
    case (fwr_pkg::func_e'(cmd_i.func))
      fwr_pkg::FUNC_APPEND: cmd.append = 1'b1;
      fwr_pkg::FUNC_REMOVE: cmd.remove = 1'b1;
      default: ;
    endcase
  end

  assign gap_w[0] = 1'b0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic          prev_valid;
    logic          nxt_valid;
    fwr_pkg::rec_t nxt_rec;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = valid_vec[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign nxt_valid = 1'b0;
      assign nxt_rec   = rec_vec[i];
    end else begin : g_link
      assign nxt_valid = valid_vec[i+1];
      assign nxt_rec   = rec_vec[i+1];
    end

    fwr_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .prev_valid_i (prev_valid),
      .gap_i        (gap_w[i]),
      .nxt_valid_i  (nxt_valid),
      .nxt_rec_i    (nxt_rec),
      .valid_o      (valid_vec[i]),
      .rec_o        (rec_vec[i]),
      .gap_o        (gap_w[i+1]),
      .valid_d_o    (valid_d_vec[i]),
      .rec_d_o      (rec_d_vec[i])
    );
  end

  always_comb begin
    count_d = count_q;
    status  = fwr_pkg::ST_DONE;
    case (fwr_pkg::func_e'(cmd_i.func))
      fwr_pkg::FUNC_APPEND: begin
        if (valid_vec[Depth-1]) begin
          status = fwr_pkg::ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      fwr_pkg::FUNC_REMOVE: begin
        if (gap_w[Depth]) begin
          count_d = count_q - CntW'(1);
        end else begin
          status = fwr_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        if (count_q == '0) begin
          status = fwr_pkg::ST_EMPTY;
        end
      end
    endcase
  end

  assign cnt_ext = {5'd0, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // hold the result payload until the next accepted transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_status_q     <= status;
      res_head_valid_q <= valid_d_vec[0];
      res_head_q       <= valid_d_vec[0] ? rec_d_vec[0] : '0;
      res_count_q      <= cnt_ext[4:0];
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.status      = res_status_q;
  assign res_o.head_valid  = res_head_valid_q;
  assign res_o.head_key    = res_head_q.key;
  assign res_o.head_tag    = res_head_q.tag;
  assign res_o.head_amount = res_head_q.amount;
  assign res_o.head_price  = res_head_q.price;
  assign res_o.entry_count = res_count_q;

  `FWR_ASSERT(a_count_matches_cells, $countones(valid_vec) == count_q)
  `FWR_ASSERT(a_cells_packed, (valid_vec & (valid_vec + Depth'(1))) == '0)
  `FWR_ASSERT(a_append_grows, accept && cmd.append && !valid_vec[Depth-1] |=> count_q == $past(count_q) + CntW'(1))
  `FWR_ASSERT(a_head_flag, res_valid_q |-> res_head_valid_q == (res_count_q != 5'd0))

endmodule

[rtl/fwr_cell.sv]
module fwr_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  fwr_pkg::cmd_t cmd_i,
  input  logic          prev_valid_i,
  input  logic          gap_i,
  input  logic          nxt_valid_i,
  input  fwr_pkg::rec_t nxt_rec_i,
  output logic          valid_o,
  output fwr_pkg::rec_t rec_o,
  output logic          gap_o,
  output logic          valid_d_o,
  output fwr_pkg::rec_t rec_d_o
);

  logic          valid_q, valid_d;
  fwr_pkg::rec_t rec_q, rec_d;
  logic          hit;

  assign hit   = valid_q && (rec_q.key == cmd_i.key);
  assign gap_o = gap_i | hit;

  always_comb begin
    valid_d = valid_q;
    rec_d   = rec_q;
    if (cmd_i.en) begin
      // first empty cell takes the appended record
      if (cmd_i.append && !valid_q && prev_valid_i) begin
        valid_d = 1'b1;
        rec_d   = cmd_i.rec;
      end
      // every cell at or behind the removed one pulls from its right neighbour
      if (cmd_i.remove && gap_o) begin
        valid_d = nxt_valid_i;
        rec_d   = nxt_rec_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign valid_o   = valid_q;
  assign rec_o     = rec_q;
  assign valid_d_o = valid_d;
  assign rec_d_o   = rec_d;

endmodule
